// ===== hdl/hbpl_pkg.sv =====
// ----------------------------------------------------------------------------
// hbpl_pkg
// shared types and constants of the heartbeat peer liveness table
// ----------------------------------------------------------------------------
package hbpl_pkg;

   localparam int MAX_PEERS = 16;
   localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int SCAN_W    = $clog2(MAX_PEERS + 1);
   localparam int CNT_W     = 5;
   localparam int TIME_W    = 32;
   localparam int ADDR_W    = 32;
   localparam int SUB_W     = 8;
   localparam int IVL_W     = 16;
   localparam int LIMIT_W   = IVL_W + 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_TICK   = 2'd1,
      OP_PACKET = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_COMMIT,
      ST_DONE
   } state_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_SUB  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RSP_SUB  = 2'd2;

   localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [SUB_W-1:0] REQ_SUB_RESET  = 8'd0;
   localparam logic [SUB_W-1:0] RSP_SUB_RESET  = 8'd1;

   typedef struct packed {
      logic [ADDR_W-1:0] ip;
      logic [TIME_W-1:0] seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hdl/heartbeat_peer_liveness_table.sv =====
// ----------------------------------------------------------------------------
// heartbeat_peer_liveness_table
// peer table kept alive by heartbeats, with aging on each tick
// ----------------------------------------------------------------------------
// usage:
//  req_ channel carries one operation beat (start, tick or received packet)
//  with the current millisecond time; rsp_ returns exactly one result beat
//  per request with the send flags and the peer count after the step.
//  csr_ channel writes interval, request subtype and response subtype; it is
//  always ready; the user must see that it is only written while no request
//  is in flight, which nothing in the block enforces. start, request packets,
//  unknown subtypes and unused operations pass decode and done; ticks add a
//  sweep over the 16-entry peer ram and response packets a sweep and a
//  commit step; the sweep reads one entry per cycle through its single read
//  port and one shared compare unit.
//  one request is in work at a time; req_ready is high only when idle, so a
//  new request is accepted only after the last one's result is loaded.
// reset:
//  synchronous, active high; clears all valid bits, the peer count, the last
//  heartbeat time and loads the register defaults. no clearing pass.
// stall:
//  a finished result waits in the output register; the next request is
//  accepted meanwhile and its result holds until the pending beat is taken.
// ----------------------------------------------------------------------------
module heartbeat_peer_liveness_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [hbpl_pkg::TIME_W-1:0]     req_time_ms,
   input  logic [hbpl_pkg::SUB_W-1:0]      req_packet_subtype,
   input  logic [hbpl_pkg::ADDR_W-1:0]     req_peer_address,
   input  logic                            req_visible,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_send_request,
   output logic                            rsp_send_heartbeat,
   output logic                            rsp_send_device_list,
   output logic                            rsp_handled,
   output logic                            rsp_new_peer,
   output logic                            rsp_table_full,
   output logic [hbpl_pkg::CNT_W-1:0]      rsp_active_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hbpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hbpl_pkg::CSR_DAT_W-1:0]  csr_data
);

   localparam int MP    = hbpl_pkg::MAX_PEERS;
   localparam int IW    = hbpl_pkg::IDX_W;
   localparam int SW    = hbpl_pkg::SCAN_W;
   localparam int TW    = hbpl_pkg::TIME_W;

   hbpl_pkg::state_type state_ff, state_in;

   // configuration
   logic [hbpl_pkg::IVL_W-1:0]   interval_ff;
   logic [hbpl_pkg::SUB_W-1:0]   req_sub_ff;
   logic [hbpl_pkg::SUB_W-1:0]   rsp_sub_ff;

   // latched request
   hbpl_pkg::op_type             op_ff;
   logic [TW-1:0]                now_ff;
   logic [hbpl_pkg::SUB_W-1:0]   sub_ff;
   logic [hbpl_pkg::ADDR_W-1:0]  addr_ff;
   logic                         vis_ff;

   // table state
   logic [MP-1:0]                valid_ff, valid_in;
   logic [SW-1:0]                cnt_ff, cnt_in;
   logic [TW-1:0]                last_hb_ff, last_hb_in;

   // sweep
   logic [SW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         ev_valid_ff;
   logic [IW-1:0]                ev_idx_ff;
   logic                         hit_ff, hit_in;
   logic [IW-1:0]                hit_idx_ff, hit_idx_in;
   logic                         free_ff, free_in;
   logic [IW-1:0]                free_idx_ff, free_idx_in;

   // result flags
   logic req_f_ff, req_f_in;
   logic hb_f_ff, hb_f_in;
   logic list_f_ff, list_f_in;
   logic hand_f_ff, hand_f_in;
   logic new_f_ff, new_f_in;
   logic full_f_ff, full_f_in;

   logic                         rsp_valid_ff;
   logic                         rsp_load;

   // fsm and ram control
   logic                         accept;
   logic                         scan_issue;
   logic                         last_ev;
   logic                         ram_we;
   logic [IW-1:0]                ram_wa;
   hbpl_pkg::entry_type          ram_wd;
   hbpl_pkg::entry_type          ram_rd;
   logic [hbpl_pkg::ENTRY_W-1:0] ram_rd_bits;

   // shared compare unit
   logic [TW-1:0]                age;
   logic [hbpl_pkg::LIMIT_W-1:0] limit;
   logic                         expired;
   logic                         ent_valid;

   assign accept  = req_valid && req_ready;
   assign last_ev = ev_valid_ff && (ev_idx_ff == IW'(MP - 1));
   assign ram_rd  = hbpl_pkg::entry_type'(ram_rd_bits);

   assign ent_valid = valid_ff[ev_idx_ff];
   assign age       = now_ff - ram_rd.seen;
   assign limit     = {3'b000, interval_ff} + {1'b0, interval_ff, 2'b00};
   assign expired   = ent_valid &&
                      ({1'b0, age, 1'b0} > {(TW + 2 - hbpl_pkg::LIMIT_W)'(0), limit});

   hbpl_ram #(
      .WIDTH (hbpl_pkg::ENTRY_W),
      .DEPTH (MP)
   ) u_peer_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rd_bits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbpl_pkg::ST_IDLE: begin
            if (accept) state_in = hbpl_pkg::ST_DECODE;
         end
         hbpl_pkg::ST_DECODE: begin
            state_in = hbpl_pkg::ST_DONE;
            if (op_ff == hbpl_pkg::OP_TICK) begin
               state_in = hbpl_pkg::ST_SCAN;
            end else if (op_ff == hbpl_pkg::OP_PACKET && sub_ff != req_sub_ff &&
                         sub_ff == rsp_sub_ff) begin
               state_in = hbpl_pkg::ST_SCAN;
            end
         end
         hbpl_pkg::ST_SCAN: begin
            if (last_ev) begin
               state_in = (op_ff == hbpl_pkg::OP_TICK) ? hbpl_pkg::ST_DONE
                                                        : hbpl_pkg::ST_COMMIT;
            end
         end
         hbpl_pkg::ST_COMMIT: state_in = hbpl_pkg::ST_DONE;
         hbpl_pkg::ST_DONE: begin
            if (rsp_load) state_in = hbpl_pkg::ST_IDLE;
         end
         default: state_in = hbpl_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready  = (state_ff == hbpl_pkg::ST_IDLE);
      scan_issue = (state_ff == hbpl_pkg::ST_SCAN) && (rd_idx_ff < SW'(MP));
      ram_we     = (state_ff == hbpl_pkg::ST_COMMIT) && (hit_ff || free_ff);
      rsp_load   = (state_ff == hbpl_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // datapath
   always_comb begin
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      last_hb_in  = last_hb_ff;
      rd_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      req_f_in    = req_f_ff;
      hb_f_in     = hb_f_ff;
      list_f_in   = list_f_ff;
      hand_f_in   = hand_f_ff;
      new_f_in    = new_f_ff;
      full_f_in   = full_f_ff;
      ram_wa      = hit_ff ? hit_idx_ff : free_idx_ff;
      ram_wd.ip   = addr_ff;
      ram_wd.seen = now_ff;

      if (accept) begin
         req_f_in  = 1'b0;
         hb_f_in   = 1'b0;
         list_f_in = 1'b0;
         hand_f_in = 1'b0;
         new_f_in  = 1'b0;
         full_f_in = 1'b0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
         rd_idx_in = '0;
      end

      unique case (state_ff)
         hbpl_pkg::ST_DECODE: begin
            unique case (op_ff)
               hbpl_pkg::OP_START: begin
                  last_hb_in = now_ff - {(TW - hbpl_pkg::IVL_W)'(0), interval_ff};
                  req_f_in   = 1'b1;
               end
               hbpl_pkg::OP_TICK: begin
                  if (vis_ff && ((now_ff - last_hb_ff) >
                                 {(TW - hbpl_pkg::IVL_W)'(0), interval_ff})) begin
                     hb_f_in    = 1'b1;
                     last_hb_in = now_ff;
                  end
               end
               hbpl_pkg::OP_PACKET: begin
                  if (sub_ff == req_sub_ff) begin
                     hb_f_in   = 1'b1;
                     hand_f_in = 1'b1;
                  end else if (sub_ff == rsp_sub_ff) begin
                     hand_f_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         hbpl_pkg::ST_SCAN: begin
            if (scan_issue) rd_idx_in = rd_idx_ff + SW'(1);
            if (ev_valid_ff) begin
               if (op_ff == hbpl_pkg::OP_TICK) begin
                  if (expired) begin
                     valid_in[ev_idx_ff] = 1'b0;
                     cnt_in              = cnt_ff - SW'(1);
                     list_f_in           = 1'b1;
                  end
               end else begin
                  if (ent_valid && !hit_ff && ram_rd.ip == addr_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = ev_idx_ff;
                  end
                  if (!ent_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = ev_idx_ff;
                  end
               end
            end
         end
         hbpl_pkg::ST_COMMIT: begin
            if (!hit_ff) begin
               new_f_in = 1'b1;
               if (free_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  cnt_in                = cnt_ff + SW'(1);
                  list_f_in             = 1'b1;
               end else begin
                  full_f_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbpl_pkg::ST_IDLE;
         interval_ff  <= hbpl_pkg::INTERVAL_RESET;
         req_sub_ff   <= hbpl_pkg::REQ_SUB_RESET;
         rsp_sub_ff   <= hbpl_pkg::RSP_SUB_RESET;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         last_hb_ff   <= '0;
         rd_idx_ff    <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         cnt_ff      <= cnt_in;
         last_hb_ff  <= last_hb_in;
         rd_idx_ff   <= rd_idx_in;
         ev_valid_ff <= scan_issue;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               hbpl_pkg::CSR_INTERVAL: interval_ff <= csr_data;
               hbpl_pkg::CSR_REQ_SUB:  req_sub_ff  <= csr_data[hbpl_pkg::SUB_W-1:0];
               hbpl_pkg::CSR_RSP_SUB:  rsp_sub_ff  <= csr_data[hbpl_pkg::SUB_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= hbpl_pkg::op_type'(req_operation);
         now_ff  <= req_time_ms;
         sub_ff  <= req_packet_subtype;
         addr_ff <= req_peer_address;
         vis_ff  <= req_visible;
      end
      ev_idx_ff   <= rd_idx_ff[IW-1:0];
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      req_f_ff    <= req_f_in;
      hb_f_ff     <= hb_f_in;
      list_f_ff   <= list_f_in;
      hand_f_ff   <= hand_f_in;
      new_f_ff    <= new_f_in;
      full_f_ff   <= full_f_in;
      if (rsp_load) begin
         rsp_send_request     <= req_f_ff;
         rsp_send_heartbeat   <= hb_f_ff;
         rsp_send_device_list <= list_f_ff;
         rsp_handled          <= hand_f_ff;
         rsp_new_peer         <= new_f_ff;
         rsp_table_full       <= full_f_ff;
         rsp_active_count     <= hbpl_pkg::CNT_W'(cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== hdl/hbpl_ram.sv =====
// ----------------------------------------------------------------------------
// hbpl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module hbpl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/hbpl_checker.sv =====
// ----------------------------------------------------------------------------
// hbpl_checker
// port level checks of the heartbeat peer liveness table
// ----------------------------------------------------------------------------
module hbpl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_send_request,
   input logic                            rsp_send_heartbeat,
   input logic                            rsp_send_device_list,
   input logic                            rsp_handled,
   input logic                            rsp_new_peer,
   input logic                            rsp_table_full,
   input logic [hbpl_pkg::CNT_W-1:0]      rsp_active_count
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_send_request, rsp_send_heartbeat, rsp_send_device_list,
                  rsp_handled, rsp_new_peer, rsp_table_full, rsp_active_count}))
      else $error("rsp beat changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_count <= hbpl_pkg::CNT_W'(hbpl_pkg::MAX_PEERS))
      else $error("active count beyond table size");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |->
         rsp_new_peer && rsp_handled && !rsp_send_device_list)
      else $error("table full flag inconsistent");

   a_new_listed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_peer && !rsp_table_full |-> rsp_send_device_list)
      else $error("inserted peer without device list");

   a_start_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_request |->
         !rsp_send_heartbeat && !rsp_handled && !rsp_new_peer && !rsp_send_device_list)
      else $error("start beat carries other flags");

endmodule

bind heartbeat_peer_liveness_table hbpl_checker u_hbpl_checker (.*);

// ===== test/heartbeat_peer_liveness_table_tb.sv =====
// ----------------------------------------------------------------------------
// heartbeat_peer_liveness_table_tb
// self-checking bench for the heartbeat peer liveness table
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own copy of the peer table, the last heartbeat
// time and the registers, predicts one result beat per request beat and
// checks every result beat against the oldest prediction. a short directed
// run covers boundary ages, wrapping time, equal subtypes and a zero
// interval; random phases then sweep the registers, fill the table until new
// peers are dropped, age peers out and throttle both channels.
// ----------------------------------------------------------------------------
module heartbeat_peer_liveness_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hbpl_pkg::*;

   localparam int POOL_SIZE       = 20;
   localparam int ITEMS_PER_PHASE = 92;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic             send_request;
      logic             send_heartbeat;
      logic             send_device_list;
      logic             handled;
      logic             new_peer;
      logic             table_full;
      logic [CNT_W-1:0] active_count;
   } outcome_type;

   class liveness_scoreboard;
      logic [IVL_W-1:0]  interval;
      logic [SUB_W-1:0]  req_sub;
      logic [SUB_W-1:0]  rsp_sub;
      logic [ADDR_W-1:0] peer_ip [MAX_PEERS];
      logic [TIME_W-1:0] peer_seen [MAX_PEERS];
      bit                peer_live [MAX_PEERS];
      logic [TIME_W-1:0] last_beat;
      outcome_type       awaited [$];
      int                failures;

      function new();
         interval  = INTERVAL_RESET;
         req_sub   = REQ_SUB_RESET;
         rsp_sub   = RSP_SUB_RESET;
         last_beat = '0;
         failures  = 0;
         foreach (peer_live[i]) peer_live[i] = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_INTERVAL: interval = data[IVL_W-1:0];
            CSR_REQ_SUB:  req_sub  = data[SUB_W-1:0];
            CSR_RSP_SUB:  rsp_sub  = data[SUB_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(op_type op, logic [TIME_W-1:0] now,
                                 logic [SUB_W-1:0] sub, logic [ADDR_W-1:0] addr,
                                 logic vis);
         outcome_type       o;
         int                hit;
         int                free_slot;
         int                live_count;
         logic [TIME_W-1:0] age;
         logic [TIME_W:0]   twice_age;
         logic [LIMIT_W-1:0] limit;
         o          = '0;
         hit        = -1;
         free_slot  = -1;
         live_count = 0;
         limit      = LIMIT_W'(interval) * LIMIT_W'(5);
         case (op)
            OP_START: begin
               last_beat      = now - TIME_W'(interval);
               o.send_request = 1'b1;
            end
            OP_TICK: begin
               age = now - last_beat;
               if (vis && age > TIME_W'(interval)) begin
                  o.send_heartbeat = 1'b1;
                  last_beat        = now;
               end
               for (int i = 0; i < MAX_PEERS; i++) begin
                  if (peer_live[i]) begin
                     age       = now - peer_seen[i];
                     twice_age = {age, 1'b0};
                     if (twice_age > limit) begin
                        peer_live[i]       = 1'b0;
                        o.send_device_list = 1'b1;
                     end
                  end
               end
            end
            OP_PACKET: begin
               if (sub == req_sub) begin
                  o.send_heartbeat = 1'b1;
                  o.handled        = 1'b1;
               end else if (sub == rsp_sub) begin
                  o.handled = 1'b1;
                  for (int i = 0; i < MAX_PEERS; i++) begin
                     if (peer_live[i]) begin
                        if (hit < 0 && peer_ip[i] == addr) hit = i;
                     end else if (free_slot < 0) begin
                        free_slot = i;
                     end
                  end
                  if (hit >= 0) begin
                     peer_seen[hit] = now;
                  end else begin
                     o.new_peer = 1'b1;
                     if (free_slot >= 0) begin
                        peer_ip[free_slot]   = addr;
                        peer_seen[free_slot] = now;
                        peer_live[free_slot] = 1'b1;
                        o.send_device_list   = 1'b1;
                     end else begin
                        o.table_full = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         foreach (peer_live[i]) if (peer_live[i]) live_count++;
         o.active_count = live_count[CNT_W-1:0];
         awaited.push_back(o);
      endfunction

      function string show(outcome_type o);
         return $sformatf("req=%b hb=%b list=%b handled=%b new=%b full=%b count=%0d",
                          o.send_request, o.send_heartbeat, o.send_device_list,
                          o.handled, o.new_peer, o.table_full, o.active_count);
      endfunction

      function void flag(string what, outcome_type want, outcome_type got);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t mismatch: %s\n   expected %s\n   actual   %s",
                     $realtime, what, show(want), show(got));
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         string       bad;
         if (awaited.size() == 0) begin
            flag("result beat with nothing awaited", '0, got);
            return;
         end
         want = awaited.pop_front();
         bad  = "";
         if (got.send_request !== want.send_request)         bad = {bad, " send_request"};
         if (got.send_heartbeat !== want.send_heartbeat)     bad = {bad, " send_heartbeat"};
         if (got.send_device_list !== want.send_device_list) bad = {bad, " send_device_list"};
         if (got.handled !== want.handled)                   bad = {bad, " handled"};
         if (got.new_peer !== want.new_peer)                 bad = {bad, " new_peer"};
         if (got.table_full !== want.table_full)             bad = {bad, " table_full"};
         if (got.active_count !== want.active_count)         bad = {bad, " active_count"};
         if (bad != "") flag({"field", bad}, want, got);
      endfunction
   endclass

   logic                 clock;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_operation      = '0;
   logic [TIME_W-1:0]    req_time_ms        = '0;
   logic [SUB_W-1:0]     req_packet_subtype = '0;
   logic [ADDR_W-1:0]    req_peer_address   = '0;
   logic                 req_visible        = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready          = 1'b0;
   logic                 rsp_send_request;
   logic                 rsp_send_heartbeat;
   logic                 rsp_send_device_list;
   logic                 rsp_handled;
   logic                 rsp_new_peer;
   logic                 rsp_table_full;
   logic [CNT_W-1:0]     rsp_active_count;
   logic                 csr_valid          = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index          = '0;
   logic [CSR_DAT_W-1:0] csr_data           = '0;

   liveness_scoreboard   sb;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   rsp_hold      = 0;
   logic [TIME_W-1:0]    now_ms;
   logic [ADDR_W-1:0]    pool [POOL_SIZE];

   heartbeat_peer_liveness_table i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[heartbeat_peer_liveness_table] ERROR");
      $finish;
   end

   // result side: check accepted beats, then pick next ready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result({rsp_send_request, rsp_send_heartbeat, rsp_send_device_list,
                             rsp_handled, rsp_new_peer, rsp_table_full, rsp_active_count});
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_item(input op_type op, input logic [TIME_W-1:0] t,
                            input logic [SUB_W-1:0] sub, input logic [ADDR_W-1:0] addr,
                            input logic vis);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_time_ms        <= t;
      req_packet_subtype <= sub;
      req_peer_address   <= addr;
      req_visible        <= vis;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, t, sub, addr, vis);
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [IVL_W-1:0] ivl, input logic [SUB_W-1:0] rq,
                             input logic [SUB_W-1:0] rs);
      logic [CSR_IDX_W-1:0] regs [3];
      logic [CSR_DAT_W-1:0] vals [3];
      regs = '{CSR_INTERVAL, CSR_REQ_SUB, CSR_RSP_SUB};
      vals = '{CSR_DAT_W'(ivl), CSR_DAT_W'(rq), CSR_DAT_W'(rs)};
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= regs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(input int jump_pct, input int small_div);
      int                pick;
      op_type            op;
      logic [TIME_W-1:0] t;
      logic [SUB_W-1:0]  sub;
      logic [ADDR_W-1:0] addr;
      logic              vis;
      if ($urandom_range(99) < jump_pct)
         now_ms = now_ms + $urandom_range(4 * sb.interval + 4);
      else
         now_ms = now_ms + $urandom_range(sb.interval / small_div);
      pick = $urandom_range(99);
      op   = OP_PACKET;
      t    = now_ms;
      sub  = SUB_W'($urandom);
      addr = pool[$urandom_range(POOL_SIZE - 1)];
      vis  = 1'($urandom_range(1));
      if (pick < 6) op = OP_START;
      else if (pick < 34) op = OP_TICK;
      else if (pick < 58 || pick >= 84) sub = sb.rsp_sub;
      else if (pick < 66) sub = sb.req_sub;
      else if (pick < 74) addr = $urandom;
      else if (pick < 78) begin
         op   = OP_UNUSED;
         addr = $urandom;
      end else begin
         op   = op_type'($urandom_range(3));
         t    = $urandom;
         addr = $urandom;
      end
      send_item(op, t, sub, addr, vis);
   endtask

   initial begin : stimulus
      logic [IVL_W-1:0] ivl;
      logic [SUB_W-1:0] rq;
      logic [SUB_W-1:0] rs;
      sb = new();
      pool[0] = '0;
      pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, register defaults
      send_idle_pct = 32;
      recv_idle_pct = 67;
      send_item(OP_START,  32'h0000_0000, 8'h00, 32'h0000_0000, 1'b0);
      send_item(OP_TICK,   32'h0000_0001, 8'h00, 32'h0000_0000, 1'b1);
      send_item(OP_TICK,   32'h0000_03E9, 8'h00, 32'h0000_0000, 1'b1);
      send_item(OP_TICK,   32'h0000_03EA, 8'h00, 32'h0000_0000, 1'b0);
      send_item(OP_PACKET, 32'h0000_000A, 8'h01, 32'h0000_0000, 1'b0);
      send_item(OP_PACKET, 32'h0000_0014, 8'h01, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_PACKET, 32'h0000_0064, 8'h01, 32'h0000_0000, 1'b0);
      send_item(OP_PACKET, 32'h0000_001E, 8'h00, 32'h1234_5678, 1'b1);
      send_item(OP_PACKET, 32'h0000_0028, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      // age exactly 2.5 intervals stays, one more expires
      send_item(OP_TICK,   32'h0000_0A28, 8'h00, 32'h0000_0000, 1'b0);
      send_item(OP_TICK,   32'h0000_0A29, 8'h00, 32'h0000_0000, 1'b1);
      // time wrap
      send_item(OP_START,  32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b0);
      send_item(OP_PACKET, 32'hFFFF_FF00, 8'h01, 32'hA5A5_A5A5, 1'b0);
      send_item(OP_TICK,   32'h0000_0400, 8'h00, 32'h0000_0000, 1'b1);
      send_item(OP_TICK,   32'h0000_0900, 8'h00, 32'h0000_0000, 1'b0);
      // equal subtypes: request wins
      wait_all_answered();
      set_config(16'hFFFF, 8'hC3, 8'hC3);
      send_item(OP_PACKET, 32'h0000_0005, 8'hC3, 32'h5A5A_5A5A, 1'b1);
      send_item(OP_TICK,   32'h8000_0000, 8'h00, 32'h0000_0000, 1'b1);
      // zero interval
      wait_all_answered();
      set_config(16'h0000, 8'h00, 8'h01);
      send_item(OP_PACKET, 32'h0000_01F4, 8'h01, 32'h0F0F_0F0F, 1'b0);
      send_item(OP_TICK,   32'h0000_01F4, 8'h00, 32'h0000_0000, 1'b1);
      send_item(OP_TICK,   32'h0000_01F5, 8'h00, 32'h0000_0000, 1'b0);
      send_item(OP_START,  32'h0000_0007, 8'h00, 32'h0000_0000, 1'b0);
      // shortest interval
      wait_all_answered();
      set_config(16'h0001, 8'hFE, 8'h7F);
      send_item(OP_PACKET, 32'h0000_0007, 8'h7F, 32'h0000_0001, 1'b0);
      send_item(OP_TICK,   32'h0000_0009, 8'h00, 32'h0000_0000, 1'b1);
      send_item(OP_TICK,   32'h0000_000A, 8'h00, 32'h0000_0000, 1'b0);

      for (int p = 0; p < 6; p++) begin
         wait_all_answered();
         case (p)
            0: begin ivl = 16'd1000;  rq = 8'h00; rs = 8'h01; end
            1: begin ivl = 16'hFFFF;  rq = 8'hFF; rs = 8'h00; end
            2: begin ivl = 16'd1;     rq = 8'h5A; rs = 8'hA5; end
            4: begin ivl = 16'd250;   rq = 8'h80; rs = 8'h7F; end
            default: begin
               ivl = IVL_W'($urandom_range(65535, 1));
               rq  = SUB_W'($urandom);
               rs  = ($urandom_range(3) == 0) ? rq : SUB_W'($urandom);
            end
         endcase
         set_config(ivl, rq, rs);
         send_idle_pct = (p < 2) ? 32 : (p < 4) ? 67 : 0;
         recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 32 : 0;
         now_ms = $urandom;
         if (p == 4) rsp_hold = 300;
         if (p % 2 == 0) begin
            // walk the whole address pool so the table overflows
            for (int k = 0; k < POOL_SIZE; k++) begin
               now_ms = now_ms + $urandom_range(sb.interval / 64);
               send_item(OP_PACKET, now_ms, sb.rsp_sub, pool[k], 1'($urandom_range(1)));
            end
            for (int n = POOL_SIZE; n < ITEMS_PER_PHASE; n++) random_item(1, 64);
         end else begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(20, 4);
         end
      end

      wait_all_answered();
      repeat (40) @(posedge clock);
      if (sb.failures == 0)
         $display("[heartbeat_peer_liveness_table] OK");
      else
         $display("[heartbeat_peer_liveness_table] ERROR");
      $finish;
   end

endmodule
